@@ sv/pjq_pkg.sv @@
`timescale 1ns / 1ps

package pjq_pkg;

	localparam int FIELD_W = 8;
	localparam int CAP_W   = 6;
	localparam int TIME_W  = 16;
	localparam int MIN_W   = 11;
	localparam int SEC_W   = 6;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// floor(t / 60) = (t * RECIP) >> RECIP_SHIFT for every 16-bit t
	localparam logic [TIME_W-1:0] SEC_PER_MIN = 16'd60;
	localparam logic [TIME_W-1:0] RECIP       = 16'd34953;
	localparam int                RECIP_SHIFT = 21;
	localparam logic [TIME_W-1:0] TIME_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [FIELD_W-1:0] owner;
		logic [FIELD_W-1:0] pages;
		logic [FIELD_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic add;
		logic extract;
	} cell_ctl_t;

endpackage

@@ sv/priority_job_queue.sv @@
`timescale 1ns / 1ps

// Bounded priority queue of print jobs held in a sorted chain of cells, highest
// priority at the head and equal priorities in arrival order. An add slides the
// lower-ranked cells down one place and drops into the gap; an extract pops the
// head and slides every cell up, adding two seconds per page to a running
// completion time that saturates at 65535 s. Chain and time accumulator update
// in the accept cycle; the request then waits in s1, with req_stall high, until
// the response register is free; it then loads the running time, split into
// minutes and seconds by a reciprocal multiply. A response waiting on rsp_stall
// holds one further request in flight at most.
// capacity may be written only while idle; values above DEPTH act as DEPTH.
module priority_job_queue import pjq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         opcode,
	input  logic [FIELD_W-1:0] owner_id,
	input  logic [FIELD_W-1:0] page_count,
	input  logic [FIELD_W-1:0] job_priority,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] out_owner,
	output logic [FIELD_W-1:0] out_pages,
	output logic [FIELD_W-1:0] out_priority,
	output logic [MIN_W-1:0]   finish_minutes,
	output logic [SEC_W-1:0]   finish_seconds,
	output logic [CAP_W-1:0]   queue_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             accept;
	logic             full;
	logic             empty;
	logic             add_ok;
	logic             ext_ok;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           cell_entry [DEPTH];
	logic             cell_ge [DEPTH];

	logic             valid_s1;
	logic [1:0]       status_s1;
	entry_t           job_s1;
	logic [CAP_W-1:0] count_s1;
	logic             move;

	logic [MIN_W-1:0] minutes;
	logic [SEC_W-1:0] seconds;

	logic             rsp_valid_q;
	logic [1:0]       status_q;
	entry_t           job_q;
	logic [MIN_W-1:0] minutes_q;
	logic [SEC_W-1:0] seconds_q;
	logic [CAP_W-1:0] rsp_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	assign accept    = req_valid && !req_stall;
	assign req_stall = valid_s1;
	assign full      = (MW'(count_q) >= MW'(cap_q)) || (MW'(count_q) >= MW'(DEPTH));
	assign empty     = (count_q == '0);
	assign add_ok    = accept && (opcode == OP_ADD) && !full;
	assign ext_ok    = accept && (opcode == OP_EXTRACT) && !empty;

	assign ctl.add     = add_ok;
	assign ctl.extract = ext_ok;

	assign new_entry.owner = owner_id;
	assign new_entry.pages = page_count;
	assign new_entry.prio  = job_priority;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   prev_ge;
		entry_t prev_e;
		entry_t next_e;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_ge = 1'b1;
			assign prev_e  = new_entry;
		end else begin : g_body
			assign prev_ge = cell_ge[i-1];
			assign prev_e  = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = new_entry;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		pjq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.prev_ge    (prev_ge),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.ge         (cell_ge[i]),
			.entry      (cell_entry[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (add_ok) begin
			count_next = count_q + CW'(1);
		end else if (ext_ok) begin
			count_next = count_q - CW'(1);
		end else if (accept && (opcode == OP_CLEAR)) begin
			count_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	pjq_time u_time (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc_en  (ext_ok),
		.pages   (cell_entry[0].pages),
		.minutes (minutes),
		.seconds (seconds)
	);

	// hold the request in s1 until the response register frees up
	assign move = valid_s1 && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= CAP_W'(count_next);
			job_s1   <= ext_ok ? cell_entry[0] : '0;
			if (opcode == OP_ADD && full) begin
				status_s1 <= ST_FULL;
			end else if (opcode == OP_EXTRACT && empty) begin
				status_s1 <= ST_EMPTY;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			status_q    <= status_s1;
			job_q       <= job_s1;
			minutes_q   <= minutes;
			seconds_q   <= seconds;
			rsp_count_q <= count_s1;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign out_owner      = job_q.owner;
	assign out_pages      = job_q.pages;
	assign out_priority   = job_q.prio;
	assign finish_minutes = minutes_q;
	assign finish_seconds = seconds_q;
	assign queue_count    = rsp_count_q;

endmodule

@@ sv/pjq_cell.sv @@
`timescale 1ns / 1ps

module pjq_cell import pjq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      prev_ge,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output logic      ge,
	output entry_t    entry
);

	entry_t entry_q;

	// held job ranks at or ahead of the new one: it stays put on an add
	assign ge    = occupied && (entry_q.prio >= new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.add && !ge) begin
			entry_q <= prev_ge ? new_entry : prev_entry;
		end else if (ctl.extract) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ sv/pjq_time.sv @@
`timescale 1ns / 1ps

module pjq_time import pjq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc_en,
	input  logic [FIELD_W-1:0] pages,
	output logic [MIN_W-1:0]   minutes,
	output logic [SEC_W-1:0]   seconds
);

	logic [TIME_W-1:0]   total_q;
	logic [TIME_W:0]     sum;
	logic [2*TIME_W-1:0] prod;
	logic [MIN_W-1:0]    quot;
	logic [TIME_W-1:0]   rem;

	// two seconds per page, saturate at the top of the range
	assign sum = {1'b0, total_q} + {{(TIME_W-FIELD_W){1'b0}}, pages, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (acc_en) begin
			total_q <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		end
	end

	assign prod = total_q * RECIP;
	assign quot = prod[RECIP_SHIFT +: MIN_W];
	assign rem  = total_q - TIME_W'(quot * SEC_PER_MIN);

	always_comb begin
		if (rem >= SEC_PER_MIN) begin
			minutes = quot + MIN_W'(1);
			seconds = SEC_W'(rem - SEC_PER_MIN);
		end else begin
			minutes = quot;
			seconds = SEC_W'(rem);
		end
	end

endmodule

@@ sv/pjq_checker.sv @@
`timescale 1ns / 1ps

module pjq_checker import pjq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [1:0]         status,
	input logic [FIELD_W-1:0] out_owner,
	input logic [FIELD_W-1:0] out_pages,
	input logic [FIELD_W-1:0] out_priority,
	input logic [SEC_W-1:0]   finish_seconds,
	input logic [CAP_W-1:0]   queue_count
);

	// one request in flight: stall right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted without stalling the next one");

	a_fail_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |->
			out_owner == '0 && out_pages == '0 && out_priority == '0)
		else $error("failed request returned a job");

	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> finish_seconds < SEC_W'(60))
		else $error("seconds out of range");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> queue_count == '0)
		else $error("empty status with nonzero count");

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable({status, out_owner,
			out_pages, out_priority, finish_seconds, queue_count}))
		else $error("stalled response changed");

endmodule

bind priority_job_queue pjq_checker u_pjq_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import pjq_pkg::*;

	localparam int JOB_SLOTS = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_SHOWN = 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] owner;
		logic [FIELD_W-1:0] pages;
		logic [FIELD_W-1:0] prio;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [CAP_W-1:0]   count;
	} job_result_t;

	typedef struct packed {
		logic               set_cap;
		logic [CAP_W-1:0]   cap;
		logic [1:0]         op;
		logic [FIELD_W-1:0] owner;
		logic [FIELD_W-1:0] pages;
		logic [FIELD_W-1:0] prio;
		logic               typed;
		job_result_t        want;
	} dir_row_t;

	localparam job_result_t NO_RESULT = '0;

	localparam dir_row_t DIRECTED [0:29] = '{
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd0}},
		'{1'b0, 6'd0, OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd0}},
		'{1'b0, 6'd0, OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd0}},
		'{1'b0, 6'd0, OP_ADD, 8'hFF, 8'hFF, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd1}},
		'{1'b0, 6'd0, OP_ADD, 8'h00, 8'h00, 8'hFF, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd2}},
		'{1'b0, 6'd0, OP_ADD, 8'hA5, 8'h01, 8'hFF, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd3}},
		'{1'b0, 6'd0, OP_ADD, 8'h5A, 8'h80, 8'h80, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'h00, 11'd0, 6'd0, 6'd4}},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'h00, 8'h00, 8'hFF, 11'd0, 6'd0, 6'd3}},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'hA5, 8'h01, 8'hFF, 11'd0, 6'd2, 6'd2}},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'h5A, 8'h80, 8'h80, 11'd4, 6'd18, 6'd1}},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'hFF, 8'hFF, 8'h00, 11'd12, 6'd48, 6'd0}},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, 8'h00, 11'd12, 6'd48, 6'd0}},
		'{1'b1, 6'd1, OP_ADD, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h01, 8'h02, 8'h03, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h7E, 8'h7E, 8'h7E, 1'b1, '{ST_FULL, 8'h00, 8'h00, 8'h00, 11'd12, 6'd48, 6'd1}},
		'{1'b1, 6'd0, OP_ADD, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h81, 8'h40, 8'hC0, 1'b1, '{ST_FULL, 8'h00, 8'h00, 8'h00, 11'd12, 6'd52, 6'd0}},
		'{1'b1, 6'd63, OP_ADD, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h33, 8'h11, 8'h07, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h44, 8'h22, 8'h07, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, 8'h00, 11'd12, 6'd52, 6'd0}},
		'{1'b1, 6'd2, OP_ADD, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h10, 8'h20, 8'h05, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h11, 8'h21, 8'h09, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h12, 8'h22, 8'h0A, 1'b1, '{ST_FULL, 8'h00, 8'h00, 8'h00, 11'd12, 6'd52, 6'd2}},
		'{1'b1, 6'd1, OP_ADD, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_ADD, 8'h13, 8'h23, 8'h0B, 1'b0, NO_RESULT},
		'{1'b0, 6'd0, OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CAP_W-1:0]   cfg_data = CAP_RESET;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         opcode = OP_ADD;
	logic [FIELD_W-1:0] owner_id = '0;
	logic [FIELD_W-1:0] page_count = '0;
	logic [FIELD_W-1:0] job_priority = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [FIELD_W-1:0] out_owner;
	logic [FIELD_W-1:0] out_pages;
	logic [FIELD_W-1:0] out_priority;
	logic [MIN_W-1:0]   finish_minutes;
	logic [SEC_W-1:0]   finish_seconds;
	logic [CAP_W-1:0]   queue_count;

	// shadow of the job queue
	entry_t             job_slots [JOB_SLOTS];
	int unsigned        jobs_held = 0;
	logic [TIME_W-1:0]  run_seconds = '0;
	logic [CAP_W-1:0]   cap_setting = CAP_RESET;

	job_result_t        owed_results [$];
	int                 mismatches = 0;
	int unsigned        cycle_count = 0;
	bit                 no_idle = 1'b0;

	priority_job_queue #(.DEPTH(JOB_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.owner_id(owner_id),
		.page_count(page_count),
		.job_priority(job_priority),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.out_owner(out_owner),
		.out_pages(out_pages),
		.out_priority(out_priority),
		.finish_minutes(finish_minutes),
		.finish_seconds(finish_seconds),
		.queue_count(queue_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic job_result_t serve_request(input logic [1:0] op,
			input logic [FIELD_W-1:0] owner, input logic [FIELD_W-1:0] pages,
			input logic [FIELD_W-1:0] prio);
		job_result_t       res;
		int unsigned       room;
		int unsigned       best;
		int unsigned       i;
		logic [TIME_W:0]   sum;
		res = '0;
		room = (int'(cap_setting) > JOB_SLOTS) ? JOB_SLOTS : int'(cap_setting);
		case (op)
		OP_ADD: begin
			if (jobs_held >= room) begin
				res.status = ST_FULL;
			end else begin
				job_slots[jobs_held] = '{owner, pages, prio};
				jobs_held++;
			end
		end
		OP_EXTRACT: begin
			if (jobs_held == 0) begin
				res.status = ST_EMPTY;
			end else begin
				// earliest of the highest priority wins
				best = 0;
				for (i = 1; i < jobs_held; i++)
					if (job_slots[i].prio > job_slots[best].prio)
						best = i;
				res.owner = job_slots[best].owner;
				res.pages = job_slots[best].pages;
				res.prio  = job_slots[best].prio;
				for (i = best; i + 1 < jobs_held; i++)
					job_slots[i] = job_slots[i + 1];
				jobs_held--;
				sum = {1'b0, run_seconds} + {8'b0, res.pages, 1'b0};
				run_seconds = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			end
		end
		OP_CLEAR: begin
			jobs_held = 0;
		end
		default: begin
		end
		endcase
		res.minutes = MIN_W'(run_seconds / SEC_PER_MIN);
		res.seconds = SEC_W'(run_seconds % SEC_PER_MIN);
		res.count = CAP_W'(jobs_held);
		return res;
	endfunction

	function automatic string describe(input job_result_t r);
		return $sformatf("status=%0d owner=%02h pages=%0d prio=%0d time=%0d:%02d count=%0d",
			r.status, r.owner, r.pages, r.prio, r.minutes, r.seconds, r.count);
	endfunction

	task automatic send_job(input logic [1:0] op, input logic [FIELD_W-1:0] owner,
			input logic [FIELD_W-1:0] pages, input logic [FIELD_W-1:0] prio,
			input bit typed, input job_result_t want);
		job_result_t predicted;
		if (!no_idle && $urandom_range(99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 33)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		owner_id <= owner;
		page_count <= pages;
		job_priority <= prio;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = serve_request(op, owner, pages, prio);
		owed_results.push_back(typed ? want : predicted);
	endtask

	// drain every response before touching the capacity register
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_setting = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [FIELD_W-1:0] random_priority();
		// few distinct levels half the time, to force ties
		if ($urandom_range(1) == 0)
			return FIELD_W'($urandom_range(3) * 85);
		return FIELD_W'($urandom_range(255));
	endfunction

	task automatic send_noise();
		logic [1:0] op;
		op = ($urandom_range(1) == 0) ? OP_CLEAR : OP_UNUSED;
		send_job(op, FIELD_W'($urandom_range(255)), FIELD_W'($urandom_range(255)),
			random_priority(), 1'b0, NO_RESULT);
	endtask

	task automatic run_phase(input int requests, input bit bursts);
		int          sent;
		int          pick;
		int unsigned room;
		int          n;
		sent = 0;
		while (sent < requests) begin
			if (bursts) begin
				// up to capacity plus two adds, then up to the held count plus two extracts
				room = (int'(cap_setting) > JOB_SLOTS) ? JOB_SLOTS : int'(cap_setting);
				n = $urandom_range(room + 2, 1);
				repeat (n) begin
					send_job(OP_ADD, FIELD_W'($urandom_range(255)),
						FIELD_W'($urandom_range(255)), random_priority(), 1'b0, NO_RESULT);
				end
				sent += n;
				n = $urandom_range(jobs_held + 2, 1);
				repeat (n) begin
					send_job(OP_EXTRACT, FIELD_W'($urandom_range(255)),
						FIELD_W'($urandom_range(255)), FIELD_W'($urandom_range(255)),
						1'b0, NO_RESULT);
				end
				sent += n;
				if ($urandom_range(99) < 20) begin
					send_noise();
					sent++;
				end
			end else begin
				pick = $urandom_range(99);
				if (pick < 46) begin
					send_job(OP_ADD, FIELD_W'($urandom_range(255)),
						FIELD_W'($urandom_range(255)), random_priority(), 1'b0, NO_RESULT);
				end else if (pick < 92) begin
					send_job(OP_EXTRACT, FIELD_W'($urandom_range(255)),
						FIELD_W'($urandom_range(255)), FIELD_W'($urandom_range(255)),
						1'b0, NO_RESULT);
				end else begin
					send_noise();
				end
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin : check_responses
		job_result_t seen;
		job_result_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				seen = {status, out_owner, out_pages, out_priority,
					finish_minutes, finish_seconds, queue_count};
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected response: %s", describe(seen));
				end else begin
					want = owed_results.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected %s, got %s",
								describe(want), describe(seen));
					end
				end
			end
			rsp_stall <= !no_idle && ($urandom_range(99) < 33);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** priority_job_queue: FAILED **");
			$finish;
		end
	end

	initial begin
		dir_row_t         row;
		int               phase;
		logic [CAP_W-1:0] cap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.set_cap)
				write_capacity(row.cap);
			else
				send_job(row.op, row.owner, row.pages, row.prio, row.typed, row.want);
		end

		// held entries carry over from phase to phase, so lowered capacities
		// can land below the held count
		for (phase = 0; phase < 12; phase++) begin
			case (phase)
			0: cap = 6'd32;
			1: cap = 6'd63;
			2: cap = 6'd1;
			3: cap = 6'd0;
			4: cap = 6'd2;
			default: begin
				if ($urandom_range(3) == 0)
					cap = CAP_W'($urandom_range(63, 33));
				else
					cap = CAP_W'($urandom_range(32, 1));
			end
			endcase
			write_capacity(cap);
			no_idle = (phase == 5);
			run_phase((phase == 5) ? 40 : 20, phase[0] == 1'b0);
		end
		no_idle = 1'b0;

		// heavy jobs push the running time into saturation
		write_capacity(6'd32);
		repeat (5) begin
			repeat (16) begin
				send_job(OP_ADD, FIELD_W'($urandom_range(255)),
					FIELD_W'($urandom_range(255, 240)), random_priority(), 1'b0, NO_RESULT);
			end
			repeat (17) begin
				send_job(OP_EXTRACT, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT);
			end
		end
		run_phase(20, 1'b0);

		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("** priority_job_queue: PASSED **");
		else
			$display("** priority_job_queue: FAILED **");
		$finish;
	end

endmodule
